// ===== rtl/hmlp_pkg.sv =====
package hmlp_pkg;

  // Depth of the kept data buffer; bytes past it are summed but not emitted.
  localparam int unsigned BUF_BYTES = 32;

  localparam logic [7:0] SUM_SEED  = 8'h55;
  localparam logic [7:0] CH_M      = 8'h4D;  // 'M'
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] TAG_DATA  = 8'h3A;  // ':'
  localparam logic [7:0] TAG_BITS  = 8'h23;  // '#'
  localparam logic [7:0] TAG_PULSE = 8'h21;  // '!'
  localparam logic [7:0] TAG_SUM   = 8'h2A;  // '*'

  localparam logic       KIND_DATA    = 1'b0;
  localparam logic       KIND_SUMMARY = 1'b1;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_SUM_BAD = 2'd1;
  localparam logic [1:0] STATUS_NOT_MSG = 2'd2;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    PH_EXPECT_M,
    PH_EXPECT_TYPE,
    PH_BODY,
    PH_STOPPED
  } phase_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [4:0] byte_index;
    logic [1:0] status;
    logic [7:0] message_type;
    logic [7:0] bit_total;
    logic [7:0] pulse_length;
    logic [5:0] stored_bytes;
    logic       sum_field_seen;
    logic       sum_matches;
    logic       run_last;
  } result_t;

  // Results produced by one character: count is 0, 1 or 2, first goes out first.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  // Bit 4 flags a hex digit, bits 3:0 carry its value.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

// ===== rtl/hmlp_parser.sv =====
module hmlp_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            take,
  input  logic [7:0]      in_character,
  input  logic            in_line_end,
  input  logic [5:0]      max_bytes,
  output hmlp_pkg::push_t push
);
  import hmlp_pkg::*;

  localparam logic [5:0] BUF_LIMIT = 6'(BUF_BYTES);

  phase_t     phase_r, phase_nxt;
  logic [7:0] tag_r, tag_nxt;
  logic       pend_r, pend_nxt;
  logic [3:0] upper_r, upper_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] bits_r, bits_nxt;
  logic [7:0] pulse_r, pulse_nxt;
  logic [5:0] count_r, count_nxt;
  logic       seen_r, seen_nxt;
  logic       ok_r, ok_nxt;
  logic [7:0] type_r, type_nxt;
  logic       rej_r, rej_nxt;

  logic [4:0] hexd;
  logic [7:0] byte_val;
  logic [5:0] limit;
  logic       byte_done;
  logic       data_emit;
  result_t    data_res;
  result_t    summ_res;

  always_comb begin
    hexd     = hex_decode(in_character);
    byte_val = {upper_r, hexd[3:0]};
    limit    = (max_bytes < BUF_LIMIT) ? max_bytes : BUF_LIMIT;

    phase_nxt = phase_r;
    tag_nxt   = tag_r;
    pend_nxt  = pend_r;
    upper_nxt = upper_r;
    sum_nxt   = sum_r;
    bits_nxt  = bits_r;
    pulse_nxt = pulse_r;
    count_nxt = count_r;
    seen_nxt  = seen_r;
    ok_nxt    = ok_r;
    type_nxt  = type_r;
    rej_nxt   = rej_r;
    byte_done = 1'b0;
    data_emit = 1'b0;
    data_res  = '0;
    summ_res  = '0;
    push      = '0;

    case (phase_r)
      PH_EXPECT_M: begin
        if (in_character == CH_M) begin
          phase_nxt = PH_EXPECT_TYPE;
        end else begin
          rej_nxt   = 1'b1;
          phase_nxt = PH_STOPPED;
        end
      end
      PH_EXPECT_TYPE: begin
        type_nxt  = in_character;
        phase_nxt = PH_BODY;
      end
      PH_BODY: begin
        if (!pend_r) begin
          if (in_line_end || in_character <= CH_SPACE) begin
            phase_nxt = PH_STOPPED;
          end else if (hexd[4]) begin
            pend_nxt  = 1'b1;
            upper_nxt = hexd[3:0];
          end else begin
            tag_nxt = in_character;
          end
        end else begin
          pend_nxt = 1'b0;
          if (hexd[4]) begin
            byte_done = 1'b1;
          end else begin
            tag_nxt = in_character;
          end
        end
      end
      default: ;
    endcase

    if (byte_done) begin
      case (tag_r)
        TAG_DATA: begin
          if (count_r < limit) begin
            data_emit           = 1'b1;
            data_res.kind       = KIND_DATA;
            data_res.data_byte  = byte_val;
            data_res.byte_index = count_r[4:0];
            count_nxt           = count_r + 6'd1;
          end
          sum_nxt = sum_r + byte_val;
        end
        TAG_BITS: begin
          bits_nxt = byte_val;
          sum_nxt  = sum_r + byte_val;
        end
        TAG_PULSE: begin
          pulse_nxt = byte_val;
          sum_nxt   = sum_r + byte_val;
        end
        TAG_SUM: begin
          seen_nxt = 1'b1;
          ok_nxt   = (byte_val == sum_r);
        end
        default: ;
      endcase
    end

    summ_res.kind     = KIND_SUMMARY;
    summ_res.run_last = 1'b1;
    if (rej_nxt) begin
      summ_res.status = STATUS_NOT_MSG;
    end else begin
      summ_res.status         = (seen_nxt && !ok_nxt) ? STATUS_SUM_BAD : STATUS_OK;
      summ_res.message_type   = type_nxt;
      summ_res.bit_total      = bits_nxt;
      summ_res.pulse_length   = pulse_nxt;
      summ_res.stored_bytes   = count_nxt;
      summ_res.sum_field_seen = seen_nxt;
      summ_res.sum_matches    = ok_nxt;
    end

    if (data_emit && in_line_end) begin
      push.count  = 2'd2;
      push.first  = data_res;
      push.second = summ_res;
    end else if (data_emit) begin
      data_res.run_last = 1'b1;
      push.count        = 2'd1;
      push.first        = data_res;
    end else if (in_line_end) begin
      push.count = 2'd1;
      push.first = summ_res;
    end

    if (in_line_end) begin
      phase_nxt = PH_EXPECT_M;
      tag_nxt   = '0;
      pend_nxt  = 1'b0;
      upper_nxt = '0;
      sum_nxt   = SUM_SEED;
      bits_nxt  = '0;
      pulse_nxt = '0;
      count_nxt = '0;
      seen_nxt  = 1'b0;
      ok_nxt    = 1'b0;
      type_nxt  = '0;
      rej_nxt   = 1'b0;
    end

    if (!take) begin
      push.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_EXPECT_M;
      tag_r   <= '0;
      pend_r  <= 1'b0;
      upper_r <= '0;
      sum_r   <= SUM_SEED;
      bits_r  <= '0;
      pulse_r <= '0;
      count_r <= '0;
      seen_r  <= 1'b0;
      ok_r    <= 1'b0;
      type_r  <= '0;
      rej_r   <= 1'b0;
    end else if (take) begin
      phase_r <= phase_nxt;
      tag_r   <= tag_nxt;
      pend_r  <= pend_nxt;
      upper_r <= upper_nxt;
      sum_r   <= sum_nxt;
      bits_r  <= bits_nxt;
      pulse_r <= pulse_nxt;
      count_r <= count_nxt;
      seen_r  <= seen_nxt;
      ok_r    <= ok_nxt;
      type_r  <= type_nxt;
      rej_r   <= rej_nxt;
    end
  end

endmodule

// ===== rtl/hmlp_outq.sv =====
module hmlp_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  hmlp_pkg::push_t   push,
  input  logic              pop,
  output logic              room_two,
  output logic              not_empty,
  output hmlp_pkg::result_t head
);
  import hmlp_pkg::*;

  result_t               entry_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wp_r, wp_nxt;
  logic [QUEUE_AW-1:0]   rp_r, rp_nxt;
  logic [QUEUE_AW:0]     fill_r, fill_nxt;
  logic [QUEUE_AW-1:0]   wp_plus1;
  logic                  do_pop;

  always_comb begin
    do_pop   = pop && (fill_r != '0);
    wp_plus1 = wp_r + QUEUE_AW'(1);
    wp_nxt   = wp_r + QUEUE_AW'(push.count);
    rp_nxt   = do_pop ? rp_r + QUEUE_AW'(1) : rp_r;
    fill_nxt = fill_r + (QUEUE_AW + 1)'(push.count) - (QUEUE_AW + 1)'(do_pop);
  end

  assign room_two  = (fill_r <= (QUEUE_AW + 1)'(QUEUE_DEPTH - 2));
  assign not_empty = (fill_r != '0);
  assign head      = entry_r[rp_r];

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entry_r[wp_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      entry_r[wp_plus1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      fill_r <= '0;
    end else begin
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
      fill_r <= fill_nxt;
    end
  end

endmodule

// ===== rtl/hex_message_line_parser.sv =====
// A character's first result is queued when its beat is taken and is offered on the out_ port
// once it reaches the queue head. Throughput: one character per cycle while in_ready is high;
// a character that yields a data byte and the summary gives two results, and the four-entry result
// queue absorbs that burst. in_ready is low while the queue has fewer than two free entries.
// Reset (rst_n low, synchronous) returns the parser to the start of a line, empties the
// result queue and sets max_bytes to 32.
module hex_message_line_parser (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_character,
  input  logic       in_line_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_kind,
  output logic [7:0] out_data_byte,
  output logic [4:0] out_byte_index,
  output logic [1:0] out_status,
  output logic [7:0] out_message_type,
  output logic [7:0] out_bit_total,
  output logic [7:0] out_pulse_length,
  output logic [5:0] out_stored_bytes,
  output logic       out_sum_field_seen,
  output logic       out_sum_matches,
  output logic       out_run_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [5:0] cfg_data
);
  import hmlp_pkg::*;

  // The user must write the configuration register only while the block is idle;
  // the block does not enforce this, and cfg_ready is tied high so it can always take a beat.
  logic [5:0] max_bytes_r;
  logic       take;
  logic       room_two;
  push_t      push;
  result_t    head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bytes_r <= 6'(BUF_BYTES);
    end else if (cfg_valid) begin
      max_bytes_r <= cfg_data;
    end
  end

  // A character is taken whenever the queue can hold the two results it may
  // cause, so its results never wait to enter the queue.
  assign in_ready = room_two;
  assign take     = in_valid && room_two;

  hmlp_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .in_character (in_character),
    .in_line_end  (in_line_end),
    .max_bytes    (max_bytes_r),
    .push         (push)
  );

  // Results sit in a small queue; its head drives the out_ beat directly.
  hmlp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (out_ready),
    .room_two  (room_two),
    .not_empty (out_valid),
    .head      (head)
  );

  assign out_kind           = head.kind;
  assign out_data_byte      = head.data_byte;
  assign out_byte_index     = head.byte_index;
  assign out_status         = head.status;
  assign out_message_type   = head.message_type;
  assign out_bit_total      = head.bit_total;
  assign out_pulse_length   = head.pulse_length;
  assign out_stored_bytes   = head.stored_bytes;
  assign out_sum_field_seen = head.sum_field_seen;
  assign out_sum_matches    = head.sum_matches;
  assign out_run_last       = head.run_last;

endmodule

// ===== verif/hmlp_line_checker.sv =====
module hmlp_line_checker
  import hmlp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_character,
  input  logic       in_line_end,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       out_kind,
  input  logic [7:0] out_data_byte,
  input  logic [4:0] out_byte_index,
  input  logic [1:0] out_status,
  input  logic [7:0] out_message_type,
  input  logic [7:0] out_bit_total,
  input  logic [7:0] out_pulse_length,
  input  logic [5:0] out_stored_bytes,
  input  logic       out_sum_field_seen,
  input  logic       out_sum_matches,
  input  logic       out_run_last,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [5:0] cfg_data,
  output int         fail_count,
  output int         expected_left,
  output int         data_checked,
  output int         summaries_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the parser state for the line in progress.
  phase_t     parse_phase;
  logic [7:0] field_tag;
  logic       nib_pending;
  logic [3:0] hi_nibble;
  logic [7:0] line_sum;
  logic [7:0] bits_field;
  logic [7:0] pulse_field;
  logic [5:0] kept_count;
  logic       sum_seen;
  logic       sum_ok;
  logic [7:0] type_char;
  logic       not_message;
  logic [5:0] max_bytes;

  result_t pending_results[$];

  task automatic clear_line();
    parse_phase = PH_EXPECT_M;
    field_tag   = '0;
    nib_pending = 1'b0;
    hi_nibble   = '0;
    line_sum    = SUM_SEED;
    bits_field  = '0;
    pulse_field = '0;
    kept_count  = '0;
    sum_seen    = 1'b0;
    sum_ok      = 1'b0;
    type_char   = '0;
    not_message = 1'b0;
  endtask

  task automatic predict_character(input logic [7:0] ch, input logic last);
    result_t    r;
    logic       is_hex;
    logic [3:0] nib;
    logic [7:0] value;
    logic [5:0] limit;
    is_hex = 1'b1;
    nib    = '0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      nib = 4'(ch - 8'h30);
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      nib = 4'(ch - 8'h57);
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      nib = 4'(ch - 8'h37);
    end else begin
      is_hex = 1'b0;
    end
    limit = (max_bytes < 6'(BUF_BYTES)) ? max_bytes : 6'(BUF_BYTES);

    case (parse_phase)
      PH_EXPECT_M: begin
        if (ch == CH_M) begin
          parse_phase = PH_EXPECT_TYPE;
        end else begin
          not_message = 1'b1;
          parse_phase = PH_STOPPED;
        end
      end
      PH_EXPECT_TYPE: begin
        type_char   = ch;
        parse_phase = PH_BODY;
      end
      PH_BODY: begin
        if (!nib_pending) begin
          if (last || ch <= CH_SPACE) begin
            parse_phase = PH_STOPPED;
          end else if (is_hex) begin
            nib_pending = 1'b1;
            hi_nibble   = nib;
          end else begin
            field_tag = ch;
          end
        end else begin
          nib_pending = 1'b0;
          if (is_hex) begin
            value = {hi_nibble, nib};
            case (field_tag)
              TAG_DATA: begin
                if (kept_count < limit) begin
                  r            = '0;
                  r.kind       = KIND_DATA;
                  r.data_byte  = value;
                  r.byte_index = kept_count[4:0];
                  r.run_last   = !last;
                  pending_results.push_back(r);
                  kept_count++;
                end
                line_sum = line_sum + value;
              end
              TAG_BITS: begin
                bits_field = value;
                line_sum   = line_sum + value;
              end
              TAG_PULSE: begin
                pulse_field = value;
                line_sum    = line_sum + value;
              end
              TAG_SUM: begin
                sum_seen = 1'b1;
                sum_ok   = (value == line_sum);
              end
              default: ;
            endcase
          end else begin
            field_tag = ch;
          end
        end
      end
      default: ;
    endcase

    if (last) begin
      r      = '0;
      r.kind = KIND_SUMMARY;
      if (not_message) begin
        r.status = STATUS_NOT_MSG;
      end else begin
        r.status         = (sum_seen && !sum_ok) ? STATUS_SUM_BAD : STATUS_OK;
        r.message_type   = type_char;
        r.bit_total      = bits_field;
        r.pulse_length   = pulse_field;
        r.stored_bytes   = kept_count;
        r.sum_field_seen = sum_seen;
        r.sum_matches    = sum_ok;
      end
      r.run_last = 1'b1;
      pending_results.push_back(r);
      clear_line();
    end
  endtask

  function automatic int check_field(input string name, input int unsigned want,
                                     input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    result_t want;
    int      errs;
    if (!rst_n) begin
      clear_line();
      max_bytes = 6'd32;
      pending_results.delete();
      fail_count        = 0;
      data_checked      = 0;
      summaries_checked = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_bytes = cfg_data;
      end
      // Results leave no earlier than the cycle after their character is taken, so the
      // output beat is retired before this edge's input beat is predicted.
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result beat: kind %0d, data_byte 0x%0h", out_kind, out_data_byte);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          errs = check_field("kind", want.kind, out_kind)
               + check_field("data_byte", want.data_byte, out_data_byte)
               + check_field("byte_index", want.byte_index, out_byte_index)
               + check_field("status", want.status, out_status)
               + check_field("message_type", want.message_type, out_message_type)
               + check_field("bit_total", want.bit_total, out_bit_total)
               + check_field("pulse_length", want.pulse_length, out_pulse_length)
               + check_field("stored_bytes", want.stored_bytes, out_stored_bytes)
               + check_field("sum_field_seen", want.sum_field_seen, out_sum_field_seen)
               + check_field("sum_matches", want.sum_matches, out_sum_matches)
               + check_field("run_last", want.run_last, out_run_last);
          if (errs != 0) begin
            fail_count++;
          end
          if (want.kind == KIND_SUMMARY) begin
            summaries_checked++;
          end else begin
            data_checked++;
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_character(in_character, in_line_end);
      end
    end
    expected_left = pending_results.size();
  end

endmodule

// ===== verif/hex_message_line_parser_tb.sv =====
module hex_message_line_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hmlp_pkg::*;

  // A run that goes this many cycles without any beat on any channel is hung.
  // The longest legitimate quiet stretch is the deliberate output hold-off.
  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 4;
  localparam int NUM_PHASES   = 8;
  localparam int PHASE_CHARS  = 110;

  // One max_bytes value per random phase; phase 5 picks a random legal value instead.
  localparam logic [5:0] MAX_BYTES_PLAN [NUM_PHASES] =
    '{6'd0, 6'd32, 6'd1, 6'd63, 6'd7, 6'd0, 6'd2, 6'd32};
  // Idle mixes, indexed by phase modulo four: none, sender gaps, receiver stalls, both.
  localparam int GAP_PLAN   [4] = '{0, 68, 0, 25};
  localparam int STALL_PLAN [4] = '{0, 0, 68, 25};

  logic       clk                = 1'b0;
  logic       rst_n              = 1'b0;
  logic       in_valid           = 1'b0;
  logic       in_ready;
  logic [7:0] in_character       = '0;
  logic       in_line_end        = 1'b0;
  logic       out_valid;
  logic       out_ready          = 1'b0;
  logic       out_kind;
  logic [7:0] out_data_byte;
  logic [4:0] out_byte_index;
  logic [1:0] out_status;
  logic [7:0] out_message_type;
  logic [7:0] out_bit_total;
  logic [7:0] out_pulse_length;
  logic [5:0] out_stored_bytes;
  logic       out_sum_field_seen;
  logic       out_sum_matches;
  logic       out_run_last;
  logic       cfg_valid          = 1'b0;
  logic       cfg_ready;
  logic [5:0] cfg_data           = '0;

  int fail_count;
  int expected_left;
  int data_checked;
  int summaries_checked;

  // Stimulus-side bookkeeping and the knobs shared with the receiver process.
  logic [7:0] line_buf[$];
  int         chars_sent  = 0;
  int         lines_sent  = 0;
  int         gap_pct     = 0;
  int         stall_pct   = 0;
  int         hold_req    = 0;
  int         quiet_cycles = 0;

  hex_message_line_parser dut (.*);

  hmlp_line_checker checker_inst (.*);

  always #10 clk = ~clk;

  // Watchdog: any accepted beat on any of the three channels counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Result receiver. A change of hold_req starts a long hold-off that this process
  // counts down on its own; otherwise out_ready follows the current stall mix.
  initial begin
    int held;
    int hold_seen;
    held      = 0;
    hold_seen = 0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        held      = HOLD_CYCLES;
      end
      if (held > 0) begin
        out_ready <= 1'b0;
        held--;
      end else begin
        out_ready <= ($urandom_range(99, 0) >= stall_pct);
      end
    end
  end

  // Drives every character of line_buf, flagging the last one as the line end.
  // Each character may be preceded by random idle cycles; valid is only lowered
  // in a step where it is not raised again, and stays high between back-to-back beats.
  task automatic send_line();
    foreach (line_buf[i]) begin
      while ($urandom_range(99, 0) < gap_pct) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
      in_valid     <= 1'b1;
      in_character <= line_buf[i];
      in_line_end  <= (i == line_buf.size() - 1);
      do @(posedge clk); while (!in_ready);
      chars_sent++;
      @(negedge clk);
    end
    lines_sent++;
  endtask

  // Appends one byte as two hex digits, letters in random case.
  task automatic push_hex(input logic [7:0] b);
    logic [3:0] n;
    for (int k = 1; k >= 0; k--) begin
      n = b[4*k +: 4];
      if (n < 4'd10) begin
        line_buf.push_back(8'h30 + 8'(n));
      end else begin
        line_buf.push_back((($urandom_range(1, 0) == 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10);
      end
    end
  endtask

  // Builds one random line. Most lines are well formed: 'M', a type, then tagged
  // fields of hex pairs with a running sum so that the checksum field can be made
  // to match. A minority are pure noise, and some well-formed lines get broken by
  // a clobbered character, an inserted space or control code, or a cut-off tail.
  task automatic build_line();
    logic [7:0] sum;
    logic [7:0] tag;
    logic [7:0] b;
    int         nbytes;
    int         pick;
    line_buf.delete();
    sum = SUM_SEED;
    if ($urandom_range(99, 0) < 8) begin
      repeat ($urandom_range(6, 1)) line_buf.push_back(8'($urandom_range(255, 0)));
      return;
    end
    line_buf.push_back(CH_M);
    line_buf.push_back(8'($urandom_range(255, 0)));
    repeat ($urandom_range(5, 0)) begin
      case ($urandom_range(5, 0))
        0, 1: tag = TAG_DATA;
        2: tag = TAG_BITS;
        3: tag = TAG_PULSE;
        4: tag = TAG_SUM;
        default: begin
          // Any other non-hex character above space acts as an unknown field tag.
          do tag = 8'($urandom_range(255, 33));
          while (tag inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66],
                             TAG_DATA, TAG_BITS, TAG_PULSE, TAG_SUM});
        end
      endcase
      line_buf.push_back(tag);
      if (tag == TAG_SUM) begin
        push_hex(($urandom_range(1, 0) == 1) ? sum : 8'($urandom_range(255, 0)));
      end else begin
        // Now and then a data field long enough that it can run past the 32-byte buffer.
        if (tag == TAG_DATA && $urandom_range(19, 0) == 0) begin
          nbytes = $urandom_range(40, 30);
        end else begin
          nbytes = $urandom_range(4, 0);
        end
        repeat (nbytes) begin
          b = 8'($urandom_range(255, 0));
          push_hex(b);
          if (tag inside {TAG_DATA, TAG_BITS, TAG_PULSE}) begin
            sum = sum + b;
          end
        end
      end
    end
    pick = $urandom_range(99, 0);
    if (pick < 10) begin
      line_buf[$urandom_range(line_buf.size() - 1, 0)] = 8'($urandom_range(255, 0));
    end else if (pick < 18) begin
      line_buf.insert($urandom_range(line_buf.size() - 1, 1), 8'($urandom_range(32, 0)));
    end else if (pick < 26 && line_buf.size() > 2) begin
      line_buf.delete(line_buf.size() - 1);
    end
  endtask

  // Lowers valid, then waits until every predicted result has been seen and then lets
  // the DRAIN_CYCLES drain period pass so the block can finish any character that yields nothing.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_left != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    logic [5:0] setting;
    int         phase_start;

    // Synchronous reset held low from time zero, then released on a falling edge.
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed lines, run at the reset value of max_bytes with no idling.
    // A lone '#' is not a message line and must be rejected.
    line_buf = '{TAG_BITS};
    send_line();
    // A line that ends right on its leading 'M'.
    line_buf = '{CH_M};
    send_line();
    // Type 0x00, every field tag once, bytes 0xFF and 0x00, mixed-case hex and a
    // checksum that matches: 0x55 + 0xFF + 0x00 + 0xA9 wraps to 0xFD.
    line_buf = '{CH_M, 8'h00, TAG_DATA, "f", "F", TAG_BITS, "0", "0",
                 TAG_PULSE, "A", "9", TAG_SUM, "F", "D"};
    send_line();
    // Type 0xFF, an unknown tag, two dropped half bytes, a space that stops
    // parsing and a final character that is ignored.
    line_buf = '{CH_M, 8'hFF, "?", "1", TAG_DATA, "3", TAG_SUM, CH_SPACE, "4"};
    send_line();

    // Random phases. Each one writes max_bytes while the block is idle, then
    // switches the idle mix. Phase 4 runs without idling and starts a long output
    // hold-off, so the result queue fills and the block backs up its input.
    for (int p = 0; p < NUM_PHASES; p++) begin
      setting = (p == 5) ? 6'($urandom_range(32, 0)) : MAX_BYTES_PLAN[p];
      wait_drained();
      cfg_valid <= 1'b1;
      cfg_data  <= setting;
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
      cfg_valid <= 1'b0;
      // Knobs change on a rising edge so the falling-edge drivers never race them.
      @(posedge clk);
      gap_pct   = GAP_PLAN[p % 4];
      stall_pct = STALL_PLAN[p % 4];
      if (p == 4) begin
        hold_req++;
      end
      @(negedge clk);
      phase_start = chars_sent;
      while (chars_sent - phase_start < PHASE_CHARS) begin
        build_line();
        send_line();
      end
    end

    wait_drained();
    $display("Run covered %0d characters in %0d lines: %0d data bytes and %0d line summaries checked.",
             chars_sent, lines_sent, data_checked, summaries_checked);
    $display("max_bytes swept over 0, 1, 2, 7, 32, 63 and one random value, with four idle mixes and a long output hold-off.");
    if (fail_count == 0 && expected_left == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/hmlp_pkg.sv
rtl/hmlp_parser.sv
rtl/hmlp_outq.sv
rtl/hex_message_line_parser.sv
verif/hmlp_line_checker.sv
verif/hex_message_line_parser_tb.sv
